[rtl/lsms_pkg.sv]
`timescale 1ns / 1ps
// Package for the LCD scanline mode sequencer: timing thresholds, widths,
// the one-hot mode type and the mapping to status mode codes. No dependencies.
package lsms_pkg;

    // Field and state widths
    localparam int ELAPSED_W = 8;
    localparam int DOT_W     = 9;
    localparam int LINE_W    = 8;
    localparam int CODE_W    = 2;
    localparam int SUM_W     = DOT_W + 1;

    // Mode thresholds in cycles, and line counts
    localparam int SEARCH_CYCLES   = 80;
    localparam int TRANSFER_CYCLES = 172;
    localparam int HBLANK_CYCLES   = 204;
    localparam int LINE_CYCLES     = 456;
    localparam int VISIBLE_LINES   = 144;
    localparam int TOTAL_LINES     = 154;

    // Largest value that dot counter plus elapsed cycles can reach
    localparam int SUM_MAX = (1 << DOT_W) - 1 + (1 << ELAPSED_W) - 1;

    // Largest threshold; the kept dot count always stays below it
    localparam int THR_MAX_A = (SEARCH_CYCLES > TRANSFER_CYCLES) ?
                               SEARCH_CYCLES : TRANSFER_CYCLES;
    localparam int THR_MAX_B = (HBLANK_CYCLES > LINE_CYCLES) ?
                               HBLANK_CYCLES : LINE_CYCLES;
    localparam int THR_MAX   = (THR_MAX_A > THR_MAX_B) ? THR_MAX_A : THR_MAX_B;

    // Status mode codes
    localparam logic [CODE_W-1:0] CODE_HBLANK   = 2'd0;
    localparam logic [CODE_W-1:0] CODE_VBLANK   = 2'd1;
    localparam logic [CODE_W-1:0] CODE_SEARCH   = 2'd2;
    localparam logic [CODE_W-1:0] CODE_TRANSFER = 2'd3;

    typedef enum logic [3:0] {
        MODE_HBLANK   = 4'b0001,
        MODE_VBLANK   = 4'b0010,
        MODE_SEARCH   = 4'b0100,
        MODE_TRANSFER = 4'b1000
    } mode_t;

    function automatic logic [CODE_W-1:0] mode_code_of(input mode_t m);
        logic [CODE_W-1:0] code;
        case (m)
            MODE_HBLANK:   code = CODE_HBLANK;
            MODE_VBLANK:   code = CODE_VBLANK;
            MODE_SEARCH:   code = CODE_SEARCH;
            MODE_TRANSFER: code = CODE_TRANSFER;
            default:       code = CODE_SEARCH;
        endcase
        return code;
    endfunction

endpackage

[rtl/lcd_scanline_mode_sequencer.sv]
`timescale 1ns / 1ps
// A transfer accepted into the input register moves on to the result register,
// which drives the outputs, when the result slot is empty or being drained.
// Throughput: one item per cycle while the output side is not stalled; the mode,
// dot and line update is one short pass of add, constant compares and subtract
// between the two registers.
// Reset (rst_n low, asynchronous): mode goes to object search, dot count and
// line to zero, both pipeline slots empty.
module lcd_scanline_mode_sequencer
    import lsms_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    // Input channel: elapsed machine cycles
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [ELAPSED_W-1:0] elapsed_cycles,

    // Output channel: status after each step
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [CODE_W-1:0]    mode_code,
    output logic [LINE_W-1:0]    current_line,
    output logic                 line_advanced
);

    // Number of multiples of each threshold that the sum can contain
    localparam int Q_SEARCH   = SUM_MAX / SEARCH_CYCLES;
    localparam int Q_TRANSFER = SUM_MAX / TRANSFER_CYCLES;
    localparam int Q_HBLANK   = SUM_MAX / HBLANK_CYCLES;
    localparam int Q_LINE     = SUM_MAX / LINE_CYCLES;

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic                 s1_valid_reg, s1_valid_next;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_free;
    logic                 s1_move;
    logic                 in_take;

    // The result slot can take a new item when it is empty or being drained
    assign out_free = !out_valid_reg || !out_stall;
    // Move the input slot into the result slot whenever both allow it
    assign s1_move  = s1_valid_reg && out_free;
    // Hold off the sender only while the input slot is full and cannot drain
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (s1_move || !s1_valid_reg)
        begin
            s1_valid_next = in_valid;
        end
        if (out_free)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Timing state update
    // ------------------------------------------------------------------
    mode_t             mode_reg, mode_next;
    logic [DOT_W-1:0]  dot_reg, dot_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic              adv_next;

    logic [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]  sub_search, sub_transfer, sub_hblank, sub_line;
    logic [SUM_W-1:0]  rem_search, rem_transfer, rem_hblank, rem_line;
    logic [LINE_W-1:0] line_inc;

    assign sum      = SUM_W'(dot_reg) + SUM_W'(elapsed_reg);
    assign line_inc = line_reg + LINE_W'(1);

    // Remainder by each constant threshold: find the largest multiple not
    // above the sum with a bank of independent compares, then subtract it.
    always_comb
    begin
        sub_search   = '0;
        sub_transfer = '0;
        sub_hblank   = '0;
        sub_line     = '0;
        for (int k = 1; k <= Q_SEARCH; k++)
        begin
            if (sum >= SUM_W'(k * SEARCH_CYCLES))
            begin
                sub_search = SUM_W'(k * SEARCH_CYCLES);
            end
        end
        for (int k = 1; k <= Q_TRANSFER; k++)
        begin
            if (sum >= SUM_W'(k * TRANSFER_CYCLES))
            begin
                sub_transfer = SUM_W'(k * TRANSFER_CYCLES);
            end
        end
        for (int k = 1; k <= Q_HBLANK; k++)
        begin
            if (sum >= SUM_W'(k * HBLANK_CYCLES))
            begin
                sub_hblank = SUM_W'(k * HBLANK_CYCLES);
            end
        end
        for (int k = 1; k <= Q_LINE; k++)
        begin
            if (sum >= SUM_W'(k * LINE_CYCLES))
            begin
                sub_line = SUM_W'(k * LINE_CYCLES);
            end
        end
    end

    assign rem_search   = sum - sub_search;
    assign rem_transfer = sum - sub_transfer;
    assign rem_hblank   = sum - sub_hblank;
    assign rem_line     = sum - sub_line;

    // At most one mode change per item; keep the sum modulo the crossed threshold
    always_comb
    begin
        mode_next = mode_reg;
        dot_next  = sum[DOT_W-1:0];
        line_next = line_reg;
        adv_next  = 1'b0;
        case (mode_reg)
            MODE_SEARCH:
            begin
                if (sum >= SUM_W'(SEARCH_CYCLES))
                begin
                    dot_next  = rem_search[DOT_W-1:0];
                    mode_next = MODE_TRANSFER;
                end
            end
            MODE_TRANSFER:
            begin
                if (sum >= SUM_W'(TRANSFER_CYCLES))
                begin
                    dot_next  = rem_transfer[DOT_W-1:0];
                    mode_next = MODE_HBLANK;
                end
            end
            MODE_HBLANK:
            begin
                if (sum >= SUM_W'(HBLANK_CYCLES))
                begin
                    dot_next  = rem_hblank[DOT_W-1:0];
                    line_next = line_inc;
                    adv_next  = 1'b1;
                    // Enter vertical blank right after the last visible line
                    mode_next = (line_inc == LINE_W'(VISIBLE_LINES)) ?
                                MODE_VBLANK : MODE_SEARCH;
                end
            end
            MODE_VBLANK:
            begin
                if (sum >= SUM_W'(LINE_CYCLES))
                begin
                    dot_next  = rem_line[DOT_W-1:0];
                    line_next = line_inc;
                    adv_next  = 1'b1;
                    // Wrap the line counter at the end of the frame
                    if (line_inc == LINE_W'(TOTAL_LINES))
                    begin
                        line_next = '0;
                        mode_next = MODE_SEARCH;
                    end
                end
            end
            default:
            begin
                mode_next = MODE_SEARCH;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [CODE_W-1:0] out_mode_reg;
    logic [LINE_W-1:0] out_line_reg;
    logic              out_adv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_SEARCH;
            dot_reg       <= '0;
            line_reg      <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            // Advance the timing state only when an item moves to the result slot
            if (s1_move)
            begin
                mode_reg <= mode_next;
                dot_reg  <= dot_next;
                line_reg <= line_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            elapsed_reg <= elapsed_cycles;
        end
        if (s1_move)
        begin
            out_mode_reg <= mode_code_of(mode_next);
            out_line_reg <= line_next;
            out_adv_reg  <= adv_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign mode_code     = out_mode_reg;
    assign current_line  = out_line_reg;
    assign line_advanced = out_adv_reg;

`ifndef NO_ASSERTIONS
    // A line step leaves the machine in object search or vertical blank
    a_adv_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && line_advanced) |->
        (mode_code == CODE_SEARCH || mode_code == CODE_VBLANK))
        else $error("line advanced into an unexpected mode");

    // The input side is held off only while its slot is occupied
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with an empty input slot");

    // The kept dot count stays below the largest threshold
    a_dot_range: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |=> (dot_reg < DOT_W'(THR_MAX)))
        else $error("dot count out of range");

    // A drained result slot with nothing behind it goes empty
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !s1_valid_reg) |=> !out_valid)
        else $error("result repeated after transfer");
`endif

endmodule

[verif/tb_lcd_scanline_mode_sequencer.sv]
`timescale 1ns / 1ps
// Self-checking testbench for lcd_scanline_mode_sequencer: directed and random
// elapsed-cycle transfers against a scoreboard that tracks the mode/dot/line state.
// Depends on lsms_pkg and the block itself.
module tb_lcd_scanline_mode_sequencer;
    import lsms_pkg::*;

    localparam int DIRECTED_ITEMS = 20;
    localparam int RANDOM_ITEMS   = 1350;
    localparam int LONG_HOLD      = 80;    // receiver hold-off that fills the pipeline
    localparam int HOLD_BURST     = 40;    // items offered back to back during the hold-off
    localparam int DRAIN_CYCLES   = 10;    // margin after every outstanding status has come back
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer on either side

    // Status expected for one elapsed-cycle step
    typedef struct {
        logic [CODE_W-1:0] code;
        logic [LINE_W-1:0] line;
        logic              advanced;
    } scan_status_t;

    // Tracks the sequencer state, computes the status of each accepted step
    // and compares the status transfers against it in order.
    class scanline_timing_board;
        logic [CODE_W-1:0] mode;
        int unsigned       dots;
        logic [LINE_W-1:0] line;
        scan_status_t      pending_status[$];
        int unsigned       errors;
        int unsigned       checked;
        int unsigned       vblank_entries;
        int unsigned       frame_wraps;

        function new();
            mode           = CODE_SEARCH;
            dots           = 0;
            line           = '0;
            errors         = 0;
            checked        = 0;
            vblank_entries = 0;
            frame_wraps    = 0;
        endfunction

        function int unsigned threshold_of_mode();
            int unsigned thr;
            case (mode)
                CODE_SEARCH:   thr = SEARCH_CYCLES;
                CODE_TRANSFER: thr = TRANSFER_CYCLES;
                CODE_HBLANK:   thr = HBLANK_CYCLES;
                default:       thr = LINE_CYCLES;
            endcase
            return thr;
        endfunction

        // Cycles still needed before the current mode's threshold is met
        function int unsigned cycles_to_threshold();
            int unsigned thr;
            thr = threshold_of_mode();
            return (dots >= thr) ? 0 : thr - dots;
        endfunction

        function void note_transfer(input logic [ELAPSED_W-1:0] elapsed);
            int unsigned  sum;
            int unsigned  thr;
            scan_status_t s;
            sum        = dots + elapsed;
            thr        = threshold_of_mode();
            s.advanced = 1'b0;
            // One threshold per step; the remainder modulo it waits for later steps
            if (sum >= thr) begin
                sum = sum % thr;
                case (mode)
                    CODE_SEARCH:   mode = CODE_TRANSFER;
                    CODE_TRANSFER: mode = CODE_HBLANK;
                    CODE_HBLANK:
                    begin
                        line       = line + 1'b1;
                        s.advanced = 1'b1;
                        if (line == VISIBLE_LINES)
                        begin
                            mode = CODE_VBLANK;
                            vblank_entries++;
                        end
                        else
                            mode = CODE_SEARCH;
                    end
                    default:
                    begin
                        line       = line + 1'b1;
                        s.advanced = 1'b1;
                        if (line == TOTAL_LINES)
                        begin
                            line = '0;
                            mode = CODE_SEARCH;
                            frame_wraps++;
                        end
                    end
                endcase
            end
            dots   = sum % (1 << DOT_W);
            s.code = mode;
            s.line = line;
            pending_status.push_back(s);
        endfunction

        function void check_status(input logic [CODE_W-1:0] code,
                                   input logic [LINE_W-1:0] ln,
                                   input logic              adv);
            scan_status_t want;
            checked++;
            if (pending_status.size() == 0)
            begin
                $error("status transfer with no step outstanding: mode_code %0d current_line %0d",
                       code, ln);
                errors++;
                return;
            end
            want = pending_status.pop_front();
            if (code !== want.code)
            begin
                $error("mode_code: expected %0d, actual %0d", want.code, code);
                errors++;
            end
            if (ln !== want.line)
            begin
                $error("current_line: expected %0d, actual %0d", want.line, ln);
                errors++;
            end
            if (adv !== want.advanced)
            begin
                $error("line_advanced: expected %0d, actual %0d", want.advanced, adv);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return pending_status.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [ELAPSED_W-1:0] elapsed_cycles;
    logic                 out_valid;
    logic                 out_stall;
    logic [CODE_W-1:0]    mode_code;
    logic [LINE_W-1:0]    current_line;
    logic                 line_advanced;

    scanline_timing_board sb = new();

    bit          hold_request = 1'b0;   // raised by the sender, cleared by the receiver
    int unsigned long_holds   = 0;
    int unsigned input_stalls = 0;
    int unsigned sent         = 0;
    int unsigned idle_cycles  = 0;

    lcd_scanline_mode_sequencer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .elapsed_cycles (elapsed_cycles),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .mode_code      (mode_code),
        .current_line   (current_line),
        .line_advanced  (line_advanced)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Offer one transfer and hold it until the block takes it. Leave in_valid
    // high so a following item can go out on the very next edge.
    task automatic offer_elapsed(input logic [ELAPSED_W-1:0] v);
        in_valid       <= 1'b1;
        elapsed_cycles <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_transfer(v);
        sent++;
    endtask

    // Drop valid for the idle stretch that n asks for; zero means keep streaming.
    task automatic idle_sender(input int unsigned n);
        if (n != 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Pick the next elapsed count. Most picks are large so the run walks through
    // whole frames; some land exactly on or just short of the current threshold.
    function automatic logic [ELAPSED_W-1:0] pick_elapsed();
        int unsigned r;
        int unsigned gap;
        r   = $urandom_range(99);
        gap = sb.cycles_to_threshold();
        if (r < 10)
            return (gap <= 255) ? gap[ELAPSED_W-1:0] : 8'hFF;
        else if (r < 15)
            return (gap >= 1 && gap <= 256) ? 8'(gap - 1) : 8'h00;
        else if (r < 25)
            return 8'($urandom_range(15));
        else if (r < 45)
            return 8'($urandom_range(255));
        else
            return 8'($urandom_range(255, 128));
    endfunction

    // Sender: reset, directed steps and threshold steps, then random bursts
    // with the two pressure episodes, then drain and report.
    initial
    begin : sender
        logic [ELAPSED_W-1:0] directed_steps [DIRECTED_ITEMS];
        int unsigned          burst;
        int unsigned          k;
        bit                   hold_done;
        bit                   drain_done;

        // Zero, one, the top value and alternating bit patterns; three maximum
        // steps leave a surplus that the following zero steps carry forward.
        directed_steps = '{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01,
                           8'h7F, 8'h80, 8'hFE, 8'h55, 8'hAA, 8'h00, 8'h01, 8'hFF,
                           8'h0F, 8'hF0, 8'h33, 8'hCC};
        hold_done      = 1'b0;
        drain_done     = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        elapsed_cycles = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_steps[i])
            offer_elapsed(directed_steps[i]);

        // Four steps of just what the current mode's threshold still needs, straight after the directed steps
        for (k = 0; k < 4; k++)
            offer_elapsed(sb.cycles_to_threshold() <= 255 ?
                          8'(sb.cycles_to_threshold()) : 8'hFF);

        while (sent < DIRECTED_ITEMS + RANDOM_ITEMS)
        begin
            burst = $urandom_range(24, 1);
            for (k = 0; k < burst; k++)
                offer_elapsed(pick_elapsed());
            if ($urandom_range(3) != 0)
                idle_sender($urandom_range(10, 1));

            // Hold off the output side for a long stretch and keep offering,
            // so the pipeline fills and the input side has to stall.
            if (!hold_done && sent > 500)
            begin
                hold_done    = 1'b1;
                hold_request = 1'b1;
                for (k = 0; k < HOLD_BURST; k++)
                    offer_elapsed(pick_elapsed());
            end

            // Pause until every outstanding status has come back.
            if (!drain_done && sent > 900)
            begin
                drain_done = 1'b1;
                in_valid  <= 1'b0;
                do
                    @(posedge clk);
                while (sb.pending() != 0);
            end
        end

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d status transfers over %0d vertical blank entries and %0d frame wraps,",
                 sb.checked, sb.vblank_entries, sb.frame_wraps);
        $display("with %0d long output hold-offs and %0d cycles of input-side stall.",
                 long_holds, input_stalls);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver: stall on a pattern that changes every window of cycles, with
    // stretches of no stall at all; serve a long hold-off when the sender asks.
    initial
    begin : receiver
        int unsigned style;
        int unsigned window;
        int unsigned period;
        int unsigned k;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            style  = $urandom_range(3);
            window = $urandom_range(200, 20);
            period = $urandom_range(7, 2);
            for (k = 0; k < window; k++)
            begin
                @(posedge clk);
                if (hold_request)
                begin
                    out_stall <= 1'b1;
                    repeat (LONG_HOLD) @(posedge clk);
                    hold_request = 1'b0;
                    long_holds++;
                end
                else
                begin
                    case (style)
                        0:       out_stall <= 1'b0;
                        1:       out_stall <= ($urandom_range(4) == 0);
                        2:       out_stall <= ($urandom_range(4) < 3);
                        default: out_stall <= ((k % period) < (period / 2));
                    endcase
                end
            end
        end
    end

    // Check every status transfer and count input stalls.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_status(mode_code, current_line, line_advanced);
            if (in_valid && in_stall)
                input_stalls++;
        end
    end

    // Watchdog: end the run if nothing moves on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no transfer for %0d cycles, %0d statuses outstanding",
                         idle_cycles, sb.pending());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

[files.f]
rtl/lsms_pkg.sv
rtl/lcd_scanline_mode_sequencer.sv
verif/tb_lcd_scanline_mode_sequencer.sv
